>>> rtl/core/usf_pkg.sv
// shared types and constants for the uart store-and-forward buffer
`default_nettype none
package usf_pkg;

  // buffer geometry
  localparam int DEPTH   = 8192;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int COUNT_W = 14;
  localparam int LIMIT_W = 4;

  // debounce limit after reset
  localparam logic [LIMIT_W-1:0] DEBOUNCE_RESET = 4'd3;

  // request codes
  typedef enum logic [1:0] {
    REQ_RX   = 2'd0,
    REQ_SLOT = 2'd1,
    REQ_TICK = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  // commands from controller to datapath
  typedef struct packed {
    logic push;     // store received byte
    logic drop;     // buffer full, mark overflow
    logic pop;      // send one byte
    logic tick;     // debounce sample
    logic done;     // request taken, capture tx_valid
  } usf_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic armed;    // button pressed or session running
  } usf_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/usf_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module usf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/usf_ctrl.sv
// controller: request handshake and command decode
`default_nettype none
module usf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       in_req_type,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire usf_pkg::usf_stat_t stat,
  output usf_pkg::usf_cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_OUT  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   take;
  usf_pkg::req_t req;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign take      = in_valid && (state_r == ST_IDLE);
  assign req       = usf_pkg::req_t'(in_req_type);

  // command decode for an accepted request
  always_comb begin
    cmd = '0;
    cmd.done = take;
    if (take) begin
      case (req)
        usf_pkg::REQ_RX: begin
          cmd.push = !stat.full;
          cmd.drop = stat.full;
        end
        usf_pkg::REQ_SLOT: begin
          cmd.pop = !stat.empty && stat.armed;
        end
        usf_pkg::REQ_TICK: begin
          cmd.tick = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/usf_datapath.sv
// datapath: circular buffer pointers, session and debounce state
`default_nettype none
module usf_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire usf_pkg::usf_cmd_t            cmd,
  output usf_pkg::usf_stat_t                stat,
  input  wire logic [7:0]                   rx_data,
  input  wire logic                         button_level,
  input  wire logic                         cfg_wr_en,
  input  wire logic [usf_pkg::LIMIT_W-1:0]  cfg_wr_data,
  output logic                              tx_valid,
  output logic [7:0]                        tx_data,
  output logic [usf_pkg::COUNT_W-1:0]       item_count,
  output logic                              overflow_flag,
  output logic                              session_busy,
  output logic                              button_held
);

  logic [usf_pkg::ADDR_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [usf_pkg::ADDR_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [usf_pkg::FILL_W-1:0]  fill_r, fill_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        sending_r, sending_nxt;
  logic                        held_r, held_nxt;
  logic                        pressed_r, pressed_nxt;
  logic [usf_pkg::LIMIT_W-1:0] chg_r, chg_nxt;
  logic [usf_pkg::LIMIT_W-1:0] limit_r;
  logic                        txv_r;
  logic [7:0]                  ram_q;

  // status to controller
  assign stat.full  = (fill_r == usf_pkg::FILL_W'(usf_pkg::DEPTH));
  assign stat.empty = (fill_r == '0);
  assign stat.armed = pressed_r || sending_r;

  // byte store, read data lands in the cycle after the pop
  usf_ram #(
    .WIDTH (8),
    .DEPTH (usf_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wr_idx_r),
    .wdata (rx_data),
    .re    (cmd.pop),
    .raddr (rd_idx_r),
    .rdata (ram_q)
  );

  // pointer, fill, session and debounce updates
  always_comb begin
    wr_idx_nxt  = wr_idx_r;
    rd_idx_nxt  = rd_idx_r;
    fill_nxt    = fill_r;
    ovf_nxt     = ovf_r;
    sending_nxt = sending_r;
    held_nxt    = held_r;
    pressed_nxt = pressed_r;
    chg_nxt     = chg_r;
    if (cmd.push) begin
      wr_idx_nxt = (wr_idx_r == usf_pkg::ADDR_W'(usf_pkg::DEPTH - 1)) ? '0
                 : wr_idx_r + 1'b1;
      fill_nxt   = fill_r + 1'b1;
    end
    if (cmd.drop) begin
      ovf_nxt = 1'b1;
    end
    if (cmd.pop) begin
      rd_idx_nxt = (rd_idx_r == usf_pkg::ADDR_W'(usf_pkg::DEPTH - 1)) ? '0
                 : rd_idx_r + 1'b1;
      fill_nxt   = fill_r - 1'b1;
      // last byte ends the session
      if (fill_r == usf_pkg::FILL_W'(1)) begin
        sending_nxt = 1'b0;
        ovf_nxt     = 1'b0;
      end else begin
        sending_nxt = 1'b1;
      end
    end
    if (cmd.tick && (button_level != held_r)) begin
      if (chg_r == limit_r) begin
        held_nxt    = button_level;
        pressed_nxt = !button_level;
        chg_nxt     = '0;
      end else begin
        chg_nxt     = chg_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r  <= '0;
      rd_idx_r  <= '0;
      fill_r    <= '0;
      ovf_r     <= 1'b0;
      sending_r <= 1'b0;
      held_r    <= 1'b0;
      pressed_r <= 1'b0;
      chg_r     <= '0;
      txv_r     <= 1'b0;
    end else begin
      wr_idx_r  <= wr_idx_nxt;
      rd_idx_r  <= rd_idx_nxt;
      fill_r    <= fill_nxt;
      ovf_r     <= ovf_nxt;
      sending_r <= sending_nxt;
      held_r    <= held_nxt;
      pressed_r <= pressed_nxt;
      chg_r     <= chg_nxt;
      if (cmd.done) txv_r <= cmd.pop;
    end
  end

  // debounce limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= usf_pkg::DEBOUNCE_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // result fields
  assign tx_valid      = txv_r;
  assign tx_data       = txv_r ? ram_q : 8'd0;
  assign item_count    = usf_pkg::COUNT_W'(fill_r);
  assign overflow_flag = ovf_r;
  assign session_busy  = sending_r;
  assign button_held   = pressed_r;

endmodule
`default_nettype wire

>>> rtl/core/uart_store_and_forward_buffer_top.sv
// top level of the uart store-and-forward buffer
// Usage:
//   Input channel (in_valid / in_stall) carries one request: in_req_type
//   selects a received byte (in_rx_data), a free transmitter slot, or a
//   button sample tick (in_button_level, 0 = pressed).
//   Every request yields exactly one result on the output channel
//   (out_valid / out_stall): the byte sent if any, the fill count,
//   the sticky overflow flag, the session flag and the debounced button.
//   The result is presented in the cycle after the request is taken; a
//   sent byte comes straight from the registered ram read. The
//   controller holds one request at a time and takes no new one until
//   its result is taken.
//   While out_stall is high the result holds and in_stall stays high.
//   cfg_wr_en / cfg_wr_data write the 4-bit debounce limit; write it only
//   while no result is pending.
//   Reset (rst_n low, synchronous) empties the buffer, ends any session,
//   clears overflow and debounce state and sets the limit to 3; no
//   clearing pass is needed.
`default_nettype none
module uart_store_and_forward_buffer_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_req_type,
  input  wire logic [7:0]                  in_rx_data,
  input  wire logic                        in_button_level,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_tx_valid,
  output logic [7:0]                       out_tx_data,
  output logic [usf_pkg::COUNT_W-1:0]      out_item_count,
  output logic                             out_overflow_flag,
  output logic                             out_session_busy,
  output logic                             out_button_held,
  input  wire logic                        cfg_wr_en,
  input  wire logic [usf_pkg::LIMIT_W-1:0] cfg_wr_data
);

  usf_pkg::usf_cmd_t  cmd;
  usf_pkg::usf_stat_t stat;

  // handshake and command decode
  usf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  // buffer and state
  usf_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .rx_data       (in_rx_data),
    .button_level  (in_button_level),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .tx_valid      (out_tx_valid),
    .tx_data       (out_tx_data),
    .item_count    (out_item_count),
    .overflow_flag (out_overflow_flag),
    .session_busy  (out_session_busy),
    .button_held   (out_button_held)
  );

endmodule
`default_nettype wire
